// File: hdl/gspc_pkg.sv
// shared constants, codes and constant functions of the gas sensor ppm converter
package gspc_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int DEN_W      = 16;
    localparam int RS_W       = 30;
    localparam int LOG_W      = 21;
    localparam int PPM_W      = 20;

    localparam logic [CFG_IDX_W-1:0] REG_CALIB_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READ_COUNT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAN_AIR   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_RES    = 8'd3;

    localparam logic [1:0] GAS_LPG  = 2'd0;
    localparam logic [1:0] GAS_CO   = 2'd1;
    localparam logic [1:0] GAS_SMK  = 2'd2;
    localparam logic [1:0] GAS_NONE = 2'd3;

    localparam logic [RS_W-1:0]  RS_MAX  = 30'h3FFF_FFFF;
    localparam logic [PPM_W-1:0] PPM_MAX = 20'hF_FFFF;

    localparam logic [39:0] CURVE_A = 40'd150733;
    localparam logic [15:0] CURVE_B [4] = '{16'd13763, 16'd47186, 16'd34734, 16'd0};
    localparam logic [15:0] CURVE_M [4] = '{16'd30802, 16'd22282, 16'd28836, 16'd1};

    localparam logic signed [39:0] EXP_LIMIT = 40'sd1310720;

    // c(k) = 2^(2^-k) in q30, each from the integer square root of the previous
    function automatic logic [31:0] exp_root(int k);
        logic [63:0] c;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_v;
        c = 64'd2 << 30;
        for (int i = 1; i <= k; i++)
        begin
            v     = c << 30;
            res   = 64'd0;
            bit_v = 64'd1 << 62;
            for (int j = 0; j < 32; j++)
            begin
                if (v >= res + bit_v)
                begin
                    v   = v - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end
                else
                begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
            c = res;
        end
        return c[31:0];
    endfunction

endpackage

// File: hdl/gspc_if.sv
// request channels of the gas sensor ppm converter: samples, results, configuration
interface gspc_in_if #(parameter int ADC_BITS = 11);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] sample;
    logic [1:0]          gas;

    modport source (output valid, output sample, output gas, input ready);
    modport sink   (input valid, input sample, input gas, output ready);
endinterface

interface gspc_out_if;
    logic        valid;
    logic        ready;
    logic [19:0] ppm;
    logic [1:0]  gas_used;
    logic        status;
    logic        sample_fault;

    modport source (output valid, output ppm, output gas_used, output status,
                    output sample_fault, input ready);
    modport sink   (input valid, input ppm, input gas_used, input status,
                    input sample_fault, output ready);
endinterface

interface gspc_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/gspc_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module gspc_div #(
    parameter int NW = 40
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [NW-1:0]              num,
    input  logic [gspc_pkg::DEN_W-1:0] den,
    output logic                       done,
    output logic [NW-1:0]              quo
);

    localparam int CW = (NW > 1) ? $clog2(NW) : 1;
    localparam int DW = gspc_pkg::DEN_W;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [NW-1:0] q_reg;
    logic [DW+1:0] trial;

    assign trial = {1'b0, rem_reg, q_reg[NW-1]} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW - 1);
                rem_reg  <= '0;
                den_reg  <= den;
                q_reg    <= num;
            end
            else if (busy_reg)
            begin
                if (trial[DW+1])
                begin
                    rem_reg <= {rem_reg[DW-2:0], q_reg[NW-1]};
                    q_reg   <= {q_reg[NW-2:0], 1'b0};
                end
                else
                begin
                    rem_reg <= trial[DW-1:0];
                    q_reg   <= {q_reg[NW-2:0], 1'b1};
                end
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// File: hdl/gas_sensor_ppm_converter.sv
// top level: sensor resistance windows, calibration and power-law ppm sequencer
//
// samples (sink): one raw sample and a curve select per request
// results (source): one ppm result at the end of each averaging window
// cfg (sink): register writes, index 0 calib_count, 1 read_count,
//   2 clean_air_factor, 3 load_resistance; always ready, take effect next cycle
// the first window after reset is the calibration and ends with status 1
// a sample passes through the shared divider and a zero sample skips it; a window
// end adds the mean division, then for the calibration the clean-air division, else
// two log2 passes (normalization shifts and 16 squarings each), the curve division
// and 16 exponent steps
// samples.ready is high only while the sequencer is idle
// the result register holds one result; a stalled receiver stalls the
// sequencer only when the next window ends before the old result is taken
// reset clears all windows, the calibration and the registers to defaults
module gas_sensor_ppm_converter #(
    parameter int ADC_BITS   = 11,
    parameter int MAX_WINDOW = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    gspc_in_if.sink            samples,
    gspc_out_if.source         results,
    gspc_cfg_if.sink           cfg
);

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = gspc_pkg::RS_W + CNT_W;
    localparam int NUM_RS = 24 + ADC_BITS;
    localparam int NUM_AB = (SUM_W > NUM_RS) ? SUM_W : NUM_RS;
    localparam int DIV_NW = (NUM_AB > 40) ? NUM_AB : 40;
    localparam int RS_W   = gspc_pkg::RS_W;
    localparam int LOG_W  = gspc_pkg::LOG_W;
    localparam int PPM_W  = gspc_pkg::PPM_W;
    localparam logic [ADC_BITS-1:0] FS = '1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RS_DIV, ST_ACC, ST_CHK, ST_MEAN, ST_RO, ST_NORM, ST_SQ,
        ST_LOGD, ST_LR, ST_EDIV, ST_PW, ST_EXP, ST_FIN, ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [6:0]          calib_count_reg, calib_count_next;
    logic [6:0]          read_count_reg, read_count_next;
    logic [15:0]         caf_reg, caf_next;
    logic [15:0]         load_reg, load_next;
    logic [1:0]          gas_reg, gas_next;
    logic                calibrated_reg, calibrated_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [RS_W-1:0]     ro_reg, ro_next;
    logic                fault_seen_reg, fault_seen_next;
    logic [RS_W-1:0]     rs_reg, rs_next;
    logic [30:0]         y_reg, y_next;
    logic [4:0]          n_reg, n_next;
    logic [15:0]         frac_reg, frac_next;
    logic [3:0]          iter_reg, iter_next;
    logic [LOG_W-1:0]    lmean_reg, lmean_next;
    logic                phase_reg, phase_next;
    logic signed [55:0]  prod_reg, prod_next;
    logic                neg_reg, neg_next;
    logic [PPM_W-1:0]    res_ppm_reg, res_ppm_next;
    logic [1:0]          res_gas_reg, res_gas_next;
    logic                res_status_reg, res_status_next;
    logic                res_fault_reg, res_fault_next;
    logic                out_valid_reg, out_valid_next;
    logic [PPM_W-1:0]    ppm_reg, ppm_next;
    logic [1:0]          gas_used_reg, gas_used_next;
    logic                status_reg, status_next;
    logic                fault_out_reg, fault_out_next;

    logic                       div_start;
    logic [DIV_NW-1:0]          div_num;
    logic [gspc_pkg::DEN_W-1:0] div_den;
    logic                       div_done;
    logic [DIV_NW-1:0]          div_quo;

    logic [31:0]                root_tab [16];
    logic [15+ADC_BITS:0]       rs_prod;
    logic [CNT_W-1:0]           target;
    logic [RS_W-1:0]            mean_q;
    logic [RS_W-1:0]            ro_eff;
    logic [61:0]                sq_w;
    logic [31:0]                sq_t;
    logic [61:0]                ex_w;
    logic signed [21:0]         d_w;
    logic signed [39:0]         lr_w;
    logic signed [39:0]         tmp_w;
    logic [39:0]                mag_w;
    logic signed [39:0]         e_w;
    logic signed [39:0]         p_w;
    logic [30:0]                r_w;

    for (genvar k = 0; k < 16; k++)
    begin : g_root
        assign root_tab[k] = gspc_pkg::exp_root(k + 1);
    end

    function automatic logic [CNT_W-1:0] eff_count(input logic [6:0] v);
        if (v == 7'd0)
            return CNT_W'(1);
        if (32'(v) > MAX_WINDOW)
            return CNT_W'(MAX_WINDOW);
        return CNT_W'(v);
    endfunction

    gspc_div #(
        .NW(DIV_NW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign samples.ready = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;

    assign results.valid        = out_valid_reg;
    assign results.ppm          = ppm_reg;
    assign results.gas_used     = gas_used_reg;
    assign results.status       = status_reg;
    assign results.sample_fault = fault_out_reg;

    assign rs_prod = load_reg * (FS - samples.sample);
    assign target  = calibrated_reg ? eff_count(read_count_reg) : eff_count(calib_count_reg);
    assign mean_q  = div_quo[RS_W-1:0];
    assign ro_eff  = (ro_reg == '0) ? RS_W'(1) : ro_reg;
    assign sq_w    = 62'(y_reg) * 62'(y_reg);
    assign sq_t    = sq_w[61:30];
    assign ex_w    = 62'(y_reg) * 62'(root_tab[iter_reg]);
    assign d_w     = $signed({1'b0, lmean_reg}) - $signed({1'b0, n_reg, frac_reg});
    assign lr_w    = prod_reg[55:16];
    assign tmp_w   = lr_w - $signed({24'd0, gspc_pkg::CURVE_B[gas_reg]});
    assign mag_w   = tmp_w[39] ? 40'(-tmp_w) : 40'(tmp_w);
    assign e_w     = neg_reg ? $signed(gspc_pkg::CURVE_A + 40'(div_quo))
                             : $signed(gspc_pkg::CURVE_A - 40'(div_quo));
    assign p_w     = prod_reg[55:16];
    assign r_w     = y_reg >> (5'd30 - n_reg);

    always_comb
    begin
        state_next       = state_reg;
        calib_count_next = calib_count_reg;
        read_count_next  = read_count_reg;
        caf_next         = caf_reg;
        load_next        = load_reg;
        gas_next         = gas_reg;
        calibrated_next  = calibrated_reg;
        cnt_next         = cnt_reg;
        sum_next         = sum_reg;
        ro_next          = ro_reg;
        fault_seen_next  = fault_seen_reg;
        rs_next          = rs_reg;
        y_next           = y_reg;
        n_next           = n_reg;
        frac_next        = frac_reg;
        iter_next        = iter_reg;
        lmean_next       = lmean_reg;
        phase_next       = phase_reg;
        prod_next        = prod_reg;
        neg_next         = neg_reg;
        res_ppm_next     = res_ppm_reg;
        res_gas_next     = res_gas_reg;
        res_status_next  = res_status_reg;
        res_fault_next   = res_fault_reg;
        out_valid_next   = out_valid_reg & ~results.ready;
        ppm_next         = ppm_reg;
        gas_used_next    = gas_used_reg;
        status_next      = status_reg;
        fault_out_next   = fault_out_reg;
        div_start        = 1'b0;
        div_num          = '0;
        div_den          = '0;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                gspc_pkg::REG_CALIB_COUNT: calib_count_next = cfg.data[6:0];
                gspc_pkg::REG_READ_COUNT:  read_count_next  = cfg.data[6:0];
                gspc_pkg::REG_CLEAN_AIR:   caf_next         = cfg.data;
                gspc_pkg::REG_LOAD_RES:    load_next        = cfg.data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    gas_next = samples.gas;
                    if (samples.sample == '0)
                    begin
                        rs_next         = gspc_pkg::RS_MAX;
                        fault_seen_next = 1'b1;
                        state_next      = ST_ACC;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_num    = DIV_NW'({rs_prod, 8'd0});
                        div_den    = gspc_pkg::DEN_W'(samples.sample);
                        state_next = ST_RS_DIV;
                    end
                end
            end
            ST_RS_DIV:
            begin
                if (div_done)
                begin
                    rs_next    = (div_quo > DIV_NW'(gspc_pkg::RS_MAX)) ? gspc_pkg::RS_MAX
                                                                       : div_quo[RS_W-1:0];
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                sum_next   = sum_reg + SUM_W'(rs_reg);
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (cnt_reg < target)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = DIV_NW'(sum_reg);
                    div_den    = gspc_pkg::DEN_W'(cnt_reg);
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                if (div_done)
                begin
                    if (!calibrated_reg)
                    begin
                        div_start  = 1'b1;
                        div_num    = DIV_NW'({mean_q, 8'd0});
                        div_den    = (caf_reg == '0) ? 16'd1 : caf_reg;
                        state_next = ST_RO;
                    end
                    else
                    begin
                        res_fault_next  = fault_seen_reg | (ro_reg == '0);
                        res_status_next = 1'b0;
                        res_gas_next    = gas_reg;
                        if (gas_reg == gspc_pkg::GAS_NONE)
                        begin
                            res_ppm_next = '0;
                            state_next   = ST_EMIT;
                        end
                        else if (mean_q == '0)
                        begin
                            res_ppm_next = gspc_pkg::PPM_MAX;
                            state_next   = ST_EMIT;
                        end
                        else
                        begin
                            y_next     = {1'b0, mean_q};
                            n_next     = 5'd30;
                            phase_next = 1'b0;
                            state_next = ST_NORM;
                        end
                    end
                end
            end
            ST_RO:
            begin
                if (div_done)
                begin
                    ro_next         = (div_quo > DIV_NW'(gspc_pkg::RS_MAX)) ? gspc_pkg::RS_MAX
                                                                            : div_quo[RS_W-1:0];
                    calibrated_next = 1'b1;
                    res_status_next = 1'b1;
                    res_ppm_next    = '0;
                    res_gas_next    = gspc_pkg::GAS_NONE;
                    res_fault_next  = fault_seen_reg;
                    state_next      = ST_EMIT;
                end
            end
            ST_NORM:
            begin
                if (y_reg[30])
                begin
                    iter_next  = '0;
                    frac_next  = '0;
                    state_next = ST_SQ;
                end
                else
                begin
                    y_next = {y_reg[29:0], 1'b0};
                    n_next = n_reg - 1'b1;
                end
            end
            ST_SQ:
            begin
                y_next    = sq_t[31] ? sq_t[31:1] : sq_t[30:0];
                frac_next = {frac_reg[14:0], sq_t[31]};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == 4'd15)
                    state_next = ST_LOGD;
            end
            ST_LOGD:
            begin
                if (!phase_reg)
                begin
                    lmean_next = {n_reg, frac_reg};
                    y_next     = {1'b0, ro_eff};
                    n_next     = 5'd30;
                    phase_next = 1'b1;
                    state_next = ST_NORM;
                end
                else
                begin
                    prod_next  = 56'(d_w) * 56'sd19728 + 56'sd32768;
                    state_next = ST_LR;
                end
            end
            ST_LR:
            begin
                neg_next   = tmp_w[39];
                div_start  = 1'b1;
                div_num    = DIV_NW'({mag_w[23:0], 16'd0});
                div_den    = gspc_pkg::CURVE_M[gas_reg];
                state_next = ST_EDIV;
            end
            ST_EDIV:
            begin
                if (div_done)
                begin
                    prod_next  = 56'(e_w) * 56'sd217706 + 56'sd32768;
                    state_next = ST_PW;
                end
            end
            ST_PW:
            begin
                if (p_w[39])
                begin
                    res_ppm_next = '0;
                    state_next   = ST_EMIT;
                end
                else if (p_w >= gspc_pkg::EXP_LIMIT)
                begin
                    res_ppm_next = gspc_pkg::PPM_MAX;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    n_next     = p_w[20:16];
                    frac_next  = p_w[15:0];
                    y_next     = 31'h4000_0000;
                    iter_next  = '0;
                    state_next = ST_EXP;
                end
            end
            ST_EXP:
            begin
                if (frac_reg[15])
                    y_next = ex_w[60:30];
                frac_next = {frac_reg[14:0], 1'b0};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == 4'd15)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                res_ppm_next = (r_w > 31'(gspc_pkg::PPM_MAX)) ? gspc_pkg::PPM_MAX
                                                               : r_w[PPM_W-1:0];
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next  = 1'b1;
                    ppm_next        = res_ppm_reg;
                    gas_used_next   = res_gas_reg;
                    status_next     = res_status_reg;
                    fault_out_next  = res_fault_reg;
                    sum_next        = '0;
                    cnt_next        = '0;
                    fault_seen_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            calib_count_reg <= 7'd25;
            read_count_reg  <= 7'd25;
            caf_reg         <= 16'd2516;
            load_reg        <= 16'd1280;
            gas_reg         <= '0;
            calibrated_reg  <= 1'b0;
            cnt_reg         <= '0;
            sum_reg         <= '0;
            ro_reg          <= '0;
            fault_seen_reg  <= 1'b0;
            rs_reg          <= '0;
            y_reg           <= '0;
            n_reg           <= '0;
            frac_reg        <= '0;
            iter_reg        <= '0;
            lmean_reg       <= '0;
            phase_reg       <= 1'b0;
            prod_reg        <= '0;
            neg_reg         <= 1'b0;
            res_ppm_reg     <= '0;
            res_gas_reg     <= '0;
            res_status_reg  <= 1'b0;
            res_fault_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            ppm_reg         <= '0;
            gas_used_reg    <= '0;
            status_reg      <= 1'b0;
            fault_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            calib_count_reg <= calib_count_next;
            read_count_reg  <= read_count_next;
            caf_reg         <= caf_next;
            load_reg        <= load_next;
            gas_reg         <= gas_next;
            calibrated_reg  <= calibrated_next;
            cnt_reg         <= cnt_next;
            sum_reg         <= sum_next;
            ro_reg          <= ro_next;
            fault_seen_reg  <= fault_seen_next;
            rs_reg          <= rs_next;
            y_reg           <= y_next;
            n_reg           <= n_next;
            frac_reg        <= frac_next;
            iter_reg        <= iter_next;
            lmean_reg       <= lmean_next;
            phase_reg       <= phase_next;
            prod_reg        <= prod_next;
            neg_reg         <= neg_next;
            res_ppm_reg     <= res_ppm_next;
            res_gas_reg     <= res_gas_next;
            res_status_reg  <= res_status_next;
            res_fault_reg   <= res_fault_next;
            out_valid_reg   <= out_valid_next;
            ppm_reg         <= ppm_next;
            gas_used_reg    <= gas_used_next;
            status_reg      <= status_next;
            fault_out_reg   <= fault_out_next;
        end
    end

endmodule
